>>> design/rfp_pkg.sv
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared widths, constants and types for the radial fade pixel pipeline.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int COORD_W         = 12;
  localparam int CHAN_W          = 8;
  localparam int CFG_W           = 12;
  localparam int CFG_IDX_W       = 2;
  localparam int DIST_FRAC       = 8;
  localparam int SCALE_FRAC_BITS = 16;

  // squared distance, radicand and root
  localparam int SQ_W        = 2 * COORD_W + 1;
  localparam int RADICAND_W  = SQ_W + 2 * DIST_FRAC;
  localparam int SQRT_STEPS  = (RADICAND_W + 1) / 2;
  localparam int RAD_PAD_W   = 2 * SQRT_STEPS;
  localparam int ROOT_W      = SQRT_STEPS;
  localparam int REM_W       = ROOT_W + 3;

  // scale division
  localparam int RAD8_W      = COORD_W + DIST_FRAC;
  localparam int SCALE_W     = SCALE_FRAC_BITS + 1;
  localparam int NUM_W       = RAD8_W + SCALE_FRAC_BITS - DIST_FRAC;
  localparam int DIV_STEPS   = SCALE_W;
  localparam int PROD_W      = CHAN_W + SCALE_W;
  localparam int PROD_HI_W   = PROD_W - SCALE_FRAC_BITS;

  localparam logic [SCALE_W-1:0] FLOOR_SCALE = SCALE_W'((1 << SCALE_FRAC_BITS) / 5);
  localparam logic [SCALE_W-1:0] UNITY_SCALE = SCALE_W'(1 << SCALE_FRAC_BITS);
  localparam logic [CHAN_W-1:0]  CHAN_MAX    = '1;

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FADE_RADIUS = CFG_IDX_W'(2);

  localparam logic [COORD_W-1:0] RADIUS_RESET = COORD_W'(1);

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

endpackage

>>> design/rfp_in_if.sv
// ----------------------------------------------------------------------------
// rfp_in_if
// Pixel request channel: coordinates and colour, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfp_in_if import rfp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] pixel_y;
  logic [CHAN_W-1:0]  red_in;
  logic [CHAN_W-1:0]  green_in;
  logic [CHAN_W-1:0]  blue_in;

  modport source (output valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, pixel_x, pixel_y, red_in, green_in, blue_in,
                  output ready);
endinterface

>>> design/rfp_out_if.sv
// ----------------------------------------------------------------------------
// rfp_out_if
// Faded pixel channel: colour only, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rfp_out_if import rfp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

>>> design/rfp_dist.sv
// ----------------------------------------------------------------------------
// rfp_dist
// Distance pipeline: offsets, sum of squares, then one root bit per stage.
// ----------------------------------------------------------------------------
module rfp_dist import rfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_in,
  input  logic [COORD_W-1:0] pixel_x,
  input  logic [COORD_W-1:0] pixel_y,
  input  rgb_t               side_in,
  input  logic [COORD_W-1:0] center_x,
  input  logic [COORD_W-1:0] center_y,
  output logic               valid_out,
  output logic [ROOT_W-1:0]  dist8,
  output rgb_t               side_out
);

  logic               vld_a;
  logic [COORD_W-1:0] dx;
  logic [COORD_W-1:0] dy;
  rgb_t               side_a;

  // offset stage
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a <= 1'b0;
    end else if (en) begin
      vld_a <= valid_in;
    end
    if (en) begin
      dx     <= (pixel_x >= center_x) ? pixel_x - center_x : center_x - pixel_x;
      dy     <= (pixel_y >= center_y) ? pixel_y - center_y : center_y - pixel_y;
      side_a <= side_in;
    end
  end

  // index 0 is the squares stage, 1..SQRT_STEPS are root stages
  logic [SQRT_STEPS:0]  vld;
  logic [ROOT_W-1:0]    root [SQRT_STEPS+1];
  logic [REM_W-1:0]     rem  [SQRT_STEPS];
  logic [RAD_PAD_W-1:0] rad  [SQRT_STEPS];
  rgb_t                 side [SQRT_STEPS+1];

  logic [2*COORD_W-1:0] dx_sq;
  logic [2*COORD_W-1:0] dy_sq;
  logic [SQ_W-1:0]      sq;

  assign dx_sq = dx * dx;
  assign dy_sq = dy * dy;
  assign sq    = {1'b0, dx_sq} + {1'b0, dy_sq};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= vld_a;
    end
    if (en) begin
      root[0] <= '0;
      rem[0]  <= '0;
      rad[0]  <= RAD_PAD_W'({sq, {(2*DIST_FRAC){1'b0}}});
      side[0] <= side_a;
    end
  end

  for (genvar k = 1; k <= SQRT_STEPS; k++) begin : g_root
    logic [REM_W-1:0] cur;
    logic [REM_W-1:0] trial;
    logic             ge;

    // bring down the next two radicand bits, try root*4+1
    assign cur   = {rem[k-1][REM_W-3:0], rad[k-1][RAD_PAD_W-1 -: 2]};
    assign trial = REM_W'({root[k-1], 2'b01});
    assign ge    = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        root[k] <= {root[k-1][ROOT_W-2:0], ge};
        side[k] <= side[k-1];
      end
    end

    if (k < SQRT_STEPS) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? cur - trial : cur;
          rad[k] <= {rad[k-1][RAD_PAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign valid_out = vld[SQRT_STEPS];
  assign dist8     = root[SQRT_STEPS];
  assign side_out  = side[SQRT_STEPS];

endmodule

>>> design/rfp_scale.sv
// ----------------------------------------------------------------------------
// rfp_scale
// Fade scale: (radius*256 - dist) * 256 / radius by restoring division,
// one quotient bit per stage, then the 0.2 floor.
// ----------------------------------------------------------------------------
module rfp_scale import rfp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               valid_in,
  input  logic [ROOT_W-1:0]  dist8,
  input  rgb_t               side_in,
  input  logic [COORD_W-1:0] fade_radius,
  output logic               valid_out,
  output logic [SCALE_W-1:0] scale,
  output rgb_t               side_out
);

  logic [RAD8_W-1:0]  rad8;
  logic               in_range;
  logic [RAD8_W-1:0]  diff;
  logic [NUM_W-1:0]   numer;
  logic [COORD_W:0]   divisor;

  assign rad8     = {fade_radius, {DIST_FRAC{1'b0}}};
  assign in_range = (fade_radius != '0) && (dist8 < ROOT_W'(rad8));
  assign diff     = rad8 - dist8[RAD8_W-1:0];
  assign numer    = in_range ? {diff, {(SCALE_FRAC_BITS-DIST_FRAC){1'b0}}} : '0;
  assign divisor  = {1'b0, fade_radius};

  // index 0 is the set-up stage; the quotient fits SCALE_W bits, so the
  // top numerator bits start out as the partial remainder
  logic [DIV_STEPS:0]   vld;
  logic [DIV_STEPS:0]   force_floor;
  logic [COORD_W-1:0]   rem  [DIV_STEPS];
  logic [DIV_STEPS-1:0] num  [DIV_STEPS];
  logic [SCALE_W-1:0]   quo  [DIV_STEPS+1];
  rgb_t                 side [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= valid_in;
    end
    if (en) begin
      rem[0]         <= COORD_W'(numer[NUM_W-1:DIV_STEPS]);
      num[0]         <= numer[DIV_STEPS-1:0];
      quo[0]         <= '0;
      force_floor[0] <= !in_range;
      side[0]        <= side_in;
    end
  end

  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
    logic [COORD_W:0] shifted;
    logic             ge;

    assign shifted = {rem[k-1], num[k-1][DIV_STEPS-1]};
    assign ge      = shifted >= divisor;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
      if (en) begin
        quo[k]         <= {quo[k-1][SCALE_W-2:0], ge};
        force_floor[k] <= force_floor[k-1];
        side[k]        <= side[k-1];
      end
    end

    if (k < DIV_STEPS) begin : g_carry
      logic [COORD_W:0] sub;
      assign sub = shifted - divisor;
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? sub[COORD_W-1:0] : shifted[COORD_W-1:0];
          num[k] <= {num[k-1][DIV_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  logic vld_f;
  rgb_t side_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_f <= 1'b0;
    end else if (en) begin
      vld_f <= vld[DIV_STEPS];
    end
    if (en) begin
      scale  <= (force_floor[DIV_STEPS] || quo[DIV_STEPS] < FLOOR_SCALE) ?
                FLOOR_SCALE : quo[DIV_STEPS];
      side_f <= side[DIV_STEPS];
    end
  end

  assign valid_out = vld_f;
  assign side_out  = side_f;

  // inside the radius the ratio never exceeds one
  a_quo_unity: assert property (@(posedge clk) disable iff (rst)
    (vld[DIV_STEPS] && !force_floor[DIV_STEPS]) |-> quo[DIV_STEPS] <= UNITY_SCALE)
    else $error("scale quotient above unity");

  a_floor_held: assert property (@(posedge clk) disable iff (rst)
    valid_out |-> (scale >= FLOOR_SCALE && scale <= UNITY_SCALE))
    else $error("scale outside floor..unity");

endmodule

>>> design/rfp_lane.sv
// ----------------------------------------------------------------------------
// rfp_lane
// One colour lane: channel times scale, registered.
// ----------------------------------------------------------------------------
module rfp_lane import rfp_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  logic [CHAN_W-1:0]  chan,
  input  logic [SCALE_W-1:0] scale,
  output logic [PROD_W-1:0]  prod
);

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(chan) * PROD_W'(scale);
    end
  end

endmodule

>>> design/radial_fade_pixel_top.sv
// ----------------------------------------------------------------------------
// radial_fade_pixel_top
// Radial vignette fade of an RGB pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   pix_in carries one request per pixel: column, row and 8-bit R/G/B.
//   pix_out returns the faded colour, one result per request, in order.
//   Both use valid/ready; a transfer happens when both are high.
//   Centre and radius are written through cfg_we/cfg_index/cfg_data
//   (0 centre x, 1 centre y, 2 radius; other indexes are dropped) and
//   must only change while nothing is in flight.
// Pipeline:
//   Request to result: offsets, squares, 21 root stages, division set-up,
//   17 quotient stages, floor, three channel lanes and the merge/output
//   register. Throughput is one pixel per clock unless pix_out stalls;
//   no pixel depends on another.
// Stall:
//   The whole pipeline holds while a result waits and pix_out.ready is
//   low; pix_in.ready drops only then.
// Reset:
//   rst empties the pipeline, sets the centre to 0,0 and the radius to 1.
// ----------------------------------------------------------------------------
module radial_fade_pixel_top import rfp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  rfp_in_if.sink               pix_in,
  rfp_out_if.source            pix_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic [COORD_W-1:0] center_x;
  logic [COORD_W-1:0] center_y;
  logic [COORD_W-1:0] fade_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x    <= '0;
      center_y    <= '0;
      fade_radius <= RADIUS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CENTER_X:    center_x    <= cfg_data[COORD_W-1:0];
        REG_CENTER_Y:    center_y    <= cfg_data[COORD_W-1:0];
        REG_FADE_RADIUS: fade_radius <= cfg_data[COORD_W-1:0];
        default: ;
      endcase
    end
  end

  logic advance;
  logic out_vld;

  assign advance      = !out_vld || pix_out.ready;
  assign pix_in.ready = advance;

  rgb_t pix_rgb;
  assign pix_rgb = '{red: pix_in.red_in, green: pix_in.green_in, blue: pix_in.blue_in};

  logic              dist_vld;
  logic [ROOT_W-1:0] dist8;
  rgb_t              dist_rgb;

  rfp_dist u_dist (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .valid_in  (pix_in.valid),
    .pixel_x   (pix_in.pixel_x),
    .pixel_y   (pix_in.pixel_y),
    .side_in   (pix_rgb),
    .center_x  (center_x),
    .center_y  (center_y),
    .valid_out (dist_vld),
    .dist8     (dist8),
    .side_out  (dist_rgb)
  );

  logic               scale_vld;
  logic [SCALE_W-1:0] scale;
  rgb_t               scale_rgb;

  rfp_scale u_scale (
    .clk         (clk),
    .rst         (rst),
    .en          (advance),
    .valid_in    (dist_vld),
    .dist8       (dist8),
    .side_in     (dist_rgb),
    .fade_radius (fade_radius),
    .valid_out   (scale_vld),
    .scale       (scale),
    .side_out    (scale_rgb)
  );

  logic              lane_vld;
  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;

  rfp_lane u_lane_r (.clk(clk), .en(advance), .chan(scale_rgb.red),   .scale(scale),
                     .prod(prod_r));
  rfp_lane u_lane_g (.clk(clk), .en(advance), .chan(scale_rgb.green), .scale(scale),
                     .prod(prod_g));
  rfp_lane u_lane_b (.clk(clk), .en(advance), .chan(scale_rgb.blue),  .scale(scale),
                     .prod(prod_b));

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_vld <= 1'b0;
    end else if (advance) begin
      lane_vld <= scale_vld;
    end
  end

  // merge: drop the fraction and clamp each lane
  logic [PROD_HI_W-1:0] hi_r;
  logic [PROD_HI_W-1:0] hi_g;
  logic [PROD_HI_W-1:0] hi_b;
  logic [CHAN_W-1:0]    red_q;
  logic [CHAN_W-1:0]    green_q;
  logic [CHAN_W-1:0]    blue_q;

  assign hi_r = prod_r[PROD_W-1:SCALE_FRAC_BITS];
  assign hi_g = prod_g[PROD_W-1:SCALE_FRAC_BITS];
  assign hi_b = prod_b[PROD_W-1:SCALE_FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= lane_vld;
    end
    if (advance) begin
      red_q   <= (hi_r > PROD_HI_W'(CHAN_MAX)) ? CHAN_MAX : hi_r[CHAN_W-1:0];
      green_q <= (hi_g > PROD_HI_W'(CHAN_MAX)) ? CHAN_MAX : hi_g[CHAN_W-1:0];
      blue_q  <= (hi_b > PROD_HI_W'(CHAN_MAX)) ? CHAN_MAX : hi_b[CHAN_W-1:0];
    end
  end

  assign pix_out.valid     = out_vld;
  assign pix_out.red_out   = red_q;
  assign pix_out.green_out = green_q;
  assign pix_out.blue_out  = blue_q;

  // back-pressure is the only reason to refuse a request
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !pix_in.ready |-> (pix_out.valid && !pix_out.ready))
    else $error("request refused without output stall");

  // scale never exceeds unity, so no lane should need the clamp
  a_lane_range: assert property (@(posedge clk) disable iff (rst)
    lane_vld |-> (hi_r <= PROD_HI_W'(CHAN_MAX) && hi_g <= PROD_HI_W'(CHAN_MAX) &&
                  hi_b <= PROD_HI_W'(CHAN_MAX)))
    else $error("lane product above channel range");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !pix_out.valid)
    else $error("result valid straight after reset");

endmodule
